[design/lsc_pkg.sv]
package lsc_pkg;

  // Coordinate width default and the widest coordinate the outcode helper takes
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned MaxCoordBits = 16;

  // Window reset values
  localparam int ResetLow  = 100;
  localparam int ResetHigh = 200;

  // Configuration register indexes
  localparam logic [1:0] RegLeft   = 2'd0;
  localparam logic [1:0] RegRight  = 2'd1;
  localparam logic [1:0] RegBottom = 2'd2;
  localparam logic [1:0] RegTop    = 2'd3;

  // Outcode bits
  localparam logic [3:0] CodeLeft  = 4'b1000;
  localparam logic [3:0] CodeRight = 4'b0100;
  localparam logic [3:0] CodeBelow = 4'b0010;
  localparam logic [3:0] CodeAbove = 4'b0001;

  // Clip rounds unrolled into the pipeline
  localparam int unsigned NumRounds = 4;

  typedef enum logic [1:0] {
    VerdictInside  = 2'd0,
    VerdictReject  = 2'd1,
    VerdictClipped = 2'd2
  } lsc_verdict_e;

  function automatic logic [3:0] outcode(
    input logic signed [MaxCoordBits-1:0] x,
    input logic signed [MaxCoordBits-1:0] y,
    input logic signed [MaxCoordBits-1:0] l,
    input logic signed [MaxCoordBits-1:0] r,
    input logic signed [MaxCoordBits-1:0] b,
    input logic signed [MaxCoordBits-1:0] t
  );
    logic [3:0] c;
    c = 4'b0000;
    if (x < l) begin
      c = c | CodeLeft;
    end else if (x > r) begin
      c = c | CodeRight;
    end
    if (y < b) begin
      c = c | CodeBelow;
    end else if (y > t) begin
      c = c | CodeAbove;
    end
    return c;
  endfunction

endpackage

[design/lsc_if.sv]
interface lsc_seg_if #(
  parameter int unsigned CoordBits = lsc_pkg::CoordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] start_x;
  logic signed [CoordBits-1:0] start_y;
  logic signed [CoordBits-1:0] end_x;
  logic signed [CoordBits-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_res_if #(
  parameter int unsigned CoordBits = lsc_pkg::CoordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  verdict;
  logic signed [CoordBits-1:0] clip_start_x;
  logic signed [CoordBits-1:0] clip_start_y;
  logic signed [CoordBits-1:0] clip_end_x;
  logic signed [CoordBits-1:0] clip_end_y;
  logic [3:0]                  start_code;
  logic [3:0]                  end_code;

  modport source (output valid, verdict, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, start_code, end_code, input ready);
  modport sink (input valid, verdict, clip_start_x, clip_start_y, clip_end_x,
                clip_end_y, start_code, end_code, output ready);
endinterface

[design/line_segment_window_clipper.sv]
// Channel  Dir  Payload
// seg      in   start_x, start_y, end_x, end_y
// res      out  verdict, clip_start_x/y, clip_end_x/y, start_code, end_code
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (left, right, bottom, top)
//
// One segment enters per cycle while res is not stalled. The pipeline is an input
// register, then four clip rounds, each with a multiplier stage and a restoring
// divider that resolves one quotient bit per stage, then an output register.
// Reset clears all valid bits and loads the window with 100..200 on both axes.
// A stall on res freezes the whole pipeline; nothing is dropped or repeated.
module line_segment_window_clipper #(
  parameter int unsigned COORD_BITS = lsc_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lsc_seg_if.sink               seg,
  lsc_res_if.source             res,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);
  import lsc_pkg::*;

  localparam int unsigned ItemW = 4 * COORD_BITS + 19;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic [3:0]                   c0;
    logic [3:0]                   c1;
    logic [3:0]                   sc;
    logic [3:0]                   ec;
    logic                         done;
    lsc_verdict_e                 verdict;
  } item_t;

  logic signed [COORD_BITS-1:0] win_l_q, win_r_q, win_b_q, win_t_q;
  logic                         en;
  item_t                        in_d, in_q, out_d, out_q;
  logic                         in_vld_q, out_vld_q;
  logic [ItemW-1:0]             rnd_item [NumRounds+1];
  logic                         rnd_vld  [NumRounds+1];

  assign en        = !out_vld_q || res.ready;
  assign seg.ready = en;

  // Window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_l_q <= COORD_BITS'(ResetLow);
      win_r_q <= COORD_BITS'(ResetHigh);
      win_b_q <= COORD_BITS'(ResetLow);
      win_t_q <= COORD_BITS'(ResetHigh);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLeft:   win_l_q <= cfg_data_i;
        RegRight:  win_r_q <= cfg_data_i;
        RegBottom: win_b_q <= cfg_data_i;
        RegTop:    win_t_q <= cfg_data_i;
        default:   win_l_q <= win_l_q;
      endcase
    end
  end

  // Compute the original outcodes
  always_comb begin
    in_d    = '0;
    in_d.x0 = seg.start_x;
    in_d.y0 = seg.start_y;
    in_d.x1 = seg.end_x;
    in_d.y1 = seg.end_y;
    in_d.c0 = outcode(MaxCoordBits'(seg.start_x), MaxCoordBits'(seg.start_y),
                      MaxCoordBits'(win_l_q), MaxCoordBits'(win_r_q),
                      MaxCoordBits'(win_b_q), MaxCoordBits'(win_t_q));
    in_d.c1 = outcode(MaxCoordBits'(seg.end_x), MaxCoordBits'(seg.end_y),
                      MaxCoordBits'(win_l_q), MaxCoordBits'(win_r_q),
                      MaxCoordBits'(win_b_q), MaxCoordBits'(win_t_q));
    in_d.sc      = in_d.c0;
    in_d.ec      = in_d.c1;
    in_d.done    = ((in_d.c0 | in_d.c1) == 4'b0000);
    in_d.verdict = in_d.done ? VerdictInside : VerdictReject;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= seg.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  assign rnd_item[0] = ItemW'(in_q);
  assign rnd_vld[0]  = in_vld_q;

  // Clip rounds
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    lsc_round #(
      .CoordBits(COORD_BITS)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (rnd_vld[r]),
      .item_i (rnd_item[r]),
      .win_l_i(win_l_q),
      .win_r_i(win_r_q),
      .win_b_i(win_b_q),
      .win_t_i(win_t_q),
      .vld_o  (rnd_vld[r+1]),
      .item_o (rnd_item[r+1])
    );
  end

  // Final check: accept, reject, or reject as undecided; zero rejected points
  always_comb begin
    out_d = item_t'(rnd_item[NumRounds]);
    if (!out_d.done) begin
      if ((out_d.c0 | out_d.c1) == 4'b0000) begin
        out_d.verdict = VerdictClipped;
      end else begin
        out_d.verdict = VerdictReject;
      end
    end
    if (out_d.verdict == VerdictReject) begin
      out_d.x0 = '0;
      out_d.y0 = '0;
      out_d.x1 = '0;
      out_d.y1 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= rnd_vld[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign res.valid        = out_vld_q;
  assign res.verdict      = out_q.verdict;
  assign res.clip_start_x = out_q.x0;
  assign res.clip_start_y = out_q.y0;
  assign res.clip_end_x   = out_q.x1;
  assign res.clip_end_y   = out_q.y1;
  assign res.start_code   = out_q.sc;
  assign res.end_code     = out_q.ec;

endmodule

[design/lsc_round.sv]
module lsc_round #(
  parameter int unsigned CoordBits = lsc_pkg::CoordBitsDef,
  localparam int unsigned ItemW = 4 * CoordBits + 19
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [ItemW-1:0]            item_i,
  input  logic signed [CoordBits-1:0] win_l_i,
  input  logic signed [CoordBits-1:0] win_r_i,
  input  logic signed [CoordBits-1:0] win_b_i,
  input  logic signed [CoordBits-1:0] win_t_i,
  output logic                        vld_o,
  output logic [ItemW-1:0]            item_o
);
  import lsc_pkg::*;

  localparam int unsigned DW  = CoordBits + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned QW  = DW;
  localparam int unsigned NSt = QW + 3;

  typedef struct packed {
    logic signed [CoordBits-1:0] x0;
    logic signed [CoordBits-1:0] y0;
    logic signed [CoordBits-1:0] x1;
    logic signed [CoordBits-1:0] y1;
    logic [3:0]                  c0;
    logic [3:0]                  c1;
    logic [3:0]                  sc;
    logic [3:0]                  ec;
    logic                        done;
    lsc_verdict_e                verdict;
  } item_t;

  typedef struct packed {
    item_t                       it;
    logic                        first;
    logic                        fix_y;
    logic signed [CoordBits-1:0] fixv;
    logic signed [CoordBits-1:0] base;
    logic signed [DW-1:0]        a;
    logic signed [DW-1:0]        f;
    logic signed [DW-1:0]        den;
    logic signed [PW-1:0]        prod;
    logic [PW-1:0]               rem;
    logic [DW-1:0]               dmag;
    logic                        neg;
    logic [QW-1:0]               q;
  } work_t;

  work_t  st_d [NSt];
  work_t  st_q [NSt];
  logic   vld_q [NSt];
  item_t  out_d;
  item_t  out_q;
  logic   out_vld_q;

  // Decide the round, then pick the endpoint and edge to clip
  always_comb begin
    item_t      d;
    logic [3:0] c;
    d = item_t'(item_i);
    st_d[0] = '0;
    if (!d.done) begin
      if ((d.c0 | d.c1) == 4'b0000) begin
        d.done    = 1'b1;
        d.verdict = VerdictClipped;
      end else if ((d.c0 & d.c1) != 4'b0000) begin
        d.done    = 1'b1;
        d.verdict = VerdictReject;
      end
    end
    st_d[0].it    = d;
    st_d[0].first = (d.c0 != 4'b0000);
    c = st_d[0].first ? d.c0 : d.c1;
    if ((c & CodeAbove) != 4'b0000) begin
      st_d[0].fix_y = 1'b1;
      st_d[0].fixv  = win_t_i;
      st_d[0].base  = d.x0;
      st_d[0].a     = DW'(d.x1) - DW'(d.x0);
      st_d[0].f     = DW'(win_t_i) - DW'(d.y0);
      st_d[0].den   = DW'(d.y1) - DW'(d.y0);
    end else if ((c & CodeBelow) != 4'b0000) begin
      st_d[0].fix_y = 1'b1;
      st_d[0].fixv  = win_b_i;
      st_d[0].base  = d.x0;
      st_d[0].a     = DW'(d.x1) - DW'(d.x0);
      st_d[0].f     = DW'(win_b_i) - DW'(d.y0);
      st_d[0].den   = DW'(d.y1) - DW'(d.y0);
    end else if ((c & CodeRight) != 4'b0000) begin
      st_d[0].fix_y = 1'b0;
      st_d[0].fixv  = win_r_i;
      st_d[0].base  = d.y0;
      st_d[0].a     = DW'(d.y1) - DW'(d.y0);
      st_d[0].f     = DW'(win_r_i) - DW'(d.x0);
      st_d[0].den   = DW'(d.x1) - DW'(d.x0);
    end else begin
      st_d[0].fix_y = 1'b0;
      st_d[0].fixv  = win_l_i;
      st_d[0].base  = d.y0;
      st_d[0].a     = DW'(d.y1) - DW'(d.y0);
      st_d[0].f     = DW'(win_l_i) - DW'(d.x0);
      st_d[0].den   = DW'(d.x1) - DW'(d.x0);
    end
  end

  // Multiply the difference by the distance to the edge
  always_comb begin
    st_d[1]      = st_q[0];
    st_d[1].prod = PW'(st_q[0].a) * PW'(st_q[0].f);
  end

  // Split into magnitudes and a quotient sign
  always_comb begin
    st_d[2]      = st_q[1];
    st_d[2].rem  = st_q[1].prod[PW-1] ? PW'(-st_q[1].prod) : PW'(st_q[1].prod);
    st_d[2].dmag = st_q[1].den[DW-1] ? DW'(-st_q[1].den) : DW'(st_q[1].den);
    st_d[2].neg  = st_q[1].prod[PW-1] ^ st_q[1].den[DW-1];
    st_d[2].q    = '0;
  end

  // Restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned Bit = QW - 1 - j;
    logic [PW-1:0] shifted;
    assign shifted = PW'(st_q[2+j].dmag) << Bit;
    always_comb begin
      st_d[3+j] = st_q[2+j];
      if (st_q[2+j].rem >= shifted) begin
        st_d[3+j].rem    = st_q[2+j].rem - shifted;
        st_d[3+j].q[Bit] = 1'b1;
      end
    end
  end

  // Move the chosen endpoint onto the edge and recompute its code
  always_comb begin
    work_t                       w;
    logic signed [DW-1:0]        qv;
    logic signed [DW-1:0]        qs;
    logic signed [CoordBits-1:0] newv;
    logic signed [CoordBits-1:0] nx;
    logic signed [CoordBits-1:0] ny;
    logic [3:0]                  nc;
    w    = st_q[NSt-1];
    qv   = signed'(w.q);
    qs   = w.neg ? -qv : qv;
    newv = CoordBits'(DW'(w.base) + qs);
    nx   = w.fix_y ? newv : w.fixv;
    ny   = w.fix_y ? w.fixv : newv;
    nc   = outcode(MaxCoordBits'(nx), MaxCoordBits'(ny), MaxCoordBits'(win_l_i),
                   MaxCoordBits'(win_r_i), MaxCoordBits'(win_b_i),
                   MaxCoordBits'(win_t_i));
    out_d = w.it;
    if (!w.it.done) begin
      if (w.first) begin
        out_d.x0 = nx;
        out_d.y0 = ny;
        out_d.c0 = nc;
      end else begin
        out_d.x1 = nx;
        out_d.y1 = ny;
        out_d.c1 = nc;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSt; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < NSt; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[NSt-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NSt; k++) begin
        st_q[k] <= st_d[k];
      end
      out_q <= out_d;
    end
  end

  assign vld_o  = out_vld_q;
  assign item_o = ItemW'(out_q);

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsc_pkg::*;

  localparam int CB = 12;
  localparam int Latency = 4 * (CB + 5) + 2;
  localparam int StallLimit = 20000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;

  typedef struct packed {
    lsc_verdict_e verdict;
    coord_t       sx;
    coord_t       sy;
    coord_t       ex;
    coord_t       ey;
    logic [3:0]   scode;
    logic [3:0]   ecode;
  } clip_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CB-1:0] cfg_data_i;

  lsc_seg_if #(.CoordBits(CB)) seg ();
  lsc_res_if #(.CoordBits(CB)) res ();

  line_segment_window_clipper #(.COORD_BITS(CB)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seg        (seg.sink),
    .res        (res.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Window copy held by the predictor
  int win_l = ResetLow, win_r = ResetHigh, win_b = ResetLow, win_t = ResetHigh;

  segment_t     pending_segs[$];
  clip_result_t expected_clips[$];
  int  errors = 0;
  int  sent = 0;
  int  received = 0;
  int  rejects = 0;
  int  clipped = 0;
  int  quiet = 0;
  bit  calm = 0;
  bit  hold_off = 0;
  bit  done = 0;
  bit  seg_fire = 0;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic logic [3:0] region_code(int x, int y);
    logic [3:0] c;
    c = '0;
    if (x < win_l) begin
      c |= CodeLeft;
    end else if (x > win_r) begin
      c |= CodeRight;
    end
    if (y < win_b) begin
      c |= CodeBelow;
    end else if (y > win_t) begin
      c |= CodeAbove;
    end
    return c;
  endfunction

  // Clip one segment against the window, repeated rounds, truncating quotients
  function automatic clip_result_t clip_segment(segment_t s);
    clip_result_t o;
    longint x0, y0, x1, y1, x, y;
    logic [3:0] c0, c1, c;
    bit first, decided;
    x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
    c0 = region_code(x0, y0);
    c1 = region_code(x1, y1);
    o.scode = c0;
    o.ecode = c1;
    decided = 0;
    o.verdict = VerdictReject;
    if ((c0 | c1) == 0) begin
      o.verdict = VerdictInside;
      decided = 1;
    end else begin
      for (int rnd = 0; rnd <= NumRounds; rnd++) begin
        if ((c0 | c1) == 0) begin
          o.verdict = VerdictClipped; decided = 1; break;
        end
        if ((c0 & c1) != 0) begin
          o.verdict = VerdictReject; decided = 1; break;
        end
        if (rnd == NumRounds) break;
        first = (c0 != 0);
        c = first ? c0 : c1;
        if (c & CodeAbove) begin
          y = win_t; x = x0 + ((x1 - x0) * (win_t - y0)) / (y1 - y0);
        end else if (c & CodeBelow) begin
          y = win_b; x = x0 + ((x1 - x0) * (win_b - y0)) / (y1 - y0);
        end else if (c & CodeRight) begin
          x = win_r; y = y0 + ((y1 - y0) * (win_r - x0)) / (x1 - x0);
        end else begin
          x = win_l; y = y0 + ((y1 - y0) * (win_l - x0)) / (x1 - x0);
        end
        if (first) begin
          x0 = x; y0 = y; c0 = region_code(x0, y0);
        end else begin
          x1 = x; y1 = y; c1 = region_code(x1, y1);
        end
      end
      if (!decided) o.verdict = VerdictReject;
    end
    if (o.verdict == VerdictReject) begin
      x0 = 0; y0 = 0; x1 = 0; y1 = 0;
    end
    o.sx = coord_t'(x0); o.sy = coord_t'(y0);
    o.ex = coord_t'(x1); o.ey = coord_t'(y1);
    return o;
  endfunction

  // Drive segments at the falling edge; hold payload until transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      seg.valid <= 1'b0;
    end else if (seg.valid && !seg_fire) begin
      // hold
    end else if (pending_segs.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
      seg.valid   <= 1'b1;
      seg.start_x <= pending_segs[0].sx;
      seg.start_y <= pending_segs[0].sy;
      seg.end_x   <= pending_segs[0].ex;
      seg.end_y   <= pending_segs[0].ey;
      void'(pending_segs.pop_front());
    end else begin
      seg.valid <= 1'b0;
    end
  end

  // Randomly stall the receiver unless held off or calm
  always @(negedge clk_i) begin
    if (hold_off) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // Predict on input transfer, check on output transfer, watch for stalls
  always @(posedge clk_i) begin
    seg_fire = rst_ni && seg.valid && seg.ready;
    if (rst_ni) begin
      if (seg.valid && seg.ready) begin
        expected_clips.push_back(clip_segment({seg.start_x, seg.start_y,
                                               seg.end_x, seg.end_y}));
        sent++;
      end
      if (res.valid && res.ready) begin
        clip_result_t got, exp_r;
        got = {lsc_verdict_e'(res.verdict), res.clip_start_x, res.clip_start_y,
               res.clip_end_x, res.clip_end_y, res.start_code, res.end_code};
        received++;
        if (expected_clips.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $realtime, got);
        end else begin
          exp_r = expected_clips.pop_front();
          if (exp_r.verdict == VerdictReject) rejects++;
          if (exp_r.verdict == VerdictClipped) clipped++;
          if (got.verdict !== exp_r.verdict || got.sx !== exp_r.sx ||
              got.sy !== exp_r.sy || got.ex !== exp_r.ex || got.ey !== exp_r.ey ||
              got.scode !== exp_r.scode || got.ecode !== exp_r.ecode) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
          end
        end
      end
      if ((seg.valid && seg.ready) || (res.valid && res.ready) || hold_off ||
          (pending_segs.size() == 0 && expected_clips.size() == 0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit && !done) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_window(logic [1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CB-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLeft:   win_l = value;
      RegRight:  win_r = value;
      RegBottom: win_b = value;
      default:   win_t = value;
    endcase
  endtask

  task automatic set_window(int l, int r, int b, int t);
    write_window(RegLeft, l);
    write_window(RegRight, r);
    write_window(RegBottom, b);
    write_window(RegTop, t);
  endtask

  task automatic drain();
    wait (pending_segs.size() == 0 && !seg.valid && expected_clips.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic int pick_coord(int lo, int hi);
    int v;
    case ($urandom_range(9))
      0: v = -2048;
      1: v = 2047;
      2: v = $urandom_range(2 * (hi - lo) + 40) + lo - (hi - lo) / 2 - 20;
      default: v = $urandom_range(hi - lo + 40) + lo - 20;
    endcase
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v;
  endfunction

  // Queue random segments, mostly near the current window
  task automatic queue_random(int count);
    segment_t s;
    int lo, hi;
    lo = (win_l < win_b) ? win_l : win_b;
    hi = (win_r > win_t) ? win_r : win_t;
    if (hi < lo) begin
      int tmp; tmp = lo; lo = hi; hi = tmp;
    end
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        s.sx = coord_t'($urandom);
        s.sy = coord_t'($urandom);
        s.ex = coord_t'($urandom);
        s.ey = coord_t'($urandom);
      end else begin
        s.sx = coord_t'(pick_coord(lo, hi));
        s.sy = coord_t'(pick_coord(lo, hi));
        s.ex = coord_t'(pick_coord(lo, hi));
        s.ey = coord_t'(pick_coord(lo, hi));
      end
      pending_segs.push_back(s);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegLeft;
    cfg_data_i = '0;
    seg.valid = 1'b0;
    seg.start_x = '0; seg.start_y = '0; seg.end_x = '0; seg.end_y = '0;
    res.ready = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: inside, shared-side reject, single and double clips, extremes
    pending_segs.push_back({12'sd150, 12'sd150, 12'sd160, 12'sd170});
    pending_segs.push_back({12'sd100, 12'sd100, 12'sd200, 12'sd200});
    pending_segs.push_back({12'sd10, 12'sd10, 12'sd50, 12'sd300});
    pending_segs.push_back({12'sd150, 12'sd150, 12'sd150, 12'sd500});
    pending_segs.push_back({12'sd150, 12'sd20, 12'sd150, 12'sd150});
    pending_segs.push_back({12'sd20, 12'sd150, 12'sd300, 12'sd150});
    pending_segs.push_back({12'sd50, 12'sd50, 12'sd250, 12'sd250});
    pending_segs.push_back({-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047});
    pending_segs.push_back({12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047});
    pending_segs.push_back({12'sd0, 12'sd180, 12'sd180, 12'sd300});
    pending_segs.push_back({12'sd90, 12'sd260, 12'sd260, 12'sd90});
    pending_segs.push_back({12'sd300, 12'sd300, 12'sd400, 12'sd50});
    pending_segs.push_back({-12'sd1, 12'sd300, 12'sd210, -12'sd7});
    drain();

    // Extreme window, then an inverted one that forces the round bound
    set_window(-2048, 2047, -2048, 2047);
    pending_segs.push_back({-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048});
    queue_random(20);
    drain();
    set_window(200, 100, 200, 100);
    pending_segs.push_back({12'sd150, 12'sd150, 12'sd160, 12'sd140});
    pending_segs.push_back({12'sd0, 12'sd0, 12'sd300, 12'sd300});
    queue_random(20);
    drain();

    // Random phases over several windows
    set_window(-300, 400, -250, 350);
    queue_random(150);
    drain();

    // Long receiver hold-off while segments keep coming
    hold_off = 1;
    queue_random(120);
    repeat (300) @(negedge clk_i);
    hold_off = 0;
    drain();

    set_window(-2048, -2000, 2000, 2047);
    queue_random(60);
    drain();
    set_window(100, 200, 100, 200);
    calm = 1;
    queue_random(100);
    drain();
    calm = 0;
    queue_random(130);

    drain();
    repeat (Latency + 10) @(negedge clk_i);
    done = 1;
    $display("Checked %0d segments (%0d clipped, %0d rejected) over six windows,",
             received, clipped, rejects);
    $display("including inverted and full-range windows and a long output stall.");
    if (errors == 0 && expected_clips.size() == 0 && received == sent) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
